FILE: rtl/core/pca_pkg.sv
// Package for the palette color allocator: types, codes and constants.
// No dependencies; imported by the top level, pca_div and pca_dist.
package pca_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam logic [30:0] DIST_LIMIT = 31'(1 << 30);
    localparam logic [7:0]  CHAN_MAX   = 8'd255;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_BEGIN = 2'd1;
    localparam logic [1:0] FUNC_OFFER = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [1:0] ST_STORED   = 2'd0;
    localparam logic [1:0] ST_CLOSE    = 2'd1;
    localparam logic [1:0] ST_NOROOM   = 2'd2;
    localparam logic [1:0] ST_DISABLED = 2'd3;

    localparam logic [2:0] ADDR_PALETTE_MODE = 3'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_SEARCH,
        S_ALLOC_DIV,
        S_ALLOC_WRITE,
        S_BEGIN_SCAN,
        S_OFFER_SCAN,
        S_OFFER_DRAIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic issue;
    } dist_ctl_t;

    typedef struct packed {
        logic        busy;
        logic [30:0] best;
    } dist_res_t;

endpackage

FILE: rtl/core/pca_if.sv
// Valid/ready channel interfaces for the request and result streams.
// Depends on nothing.
interface pca_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  end_red;
    logic [7:0]  end_green;
    logic [7:0]  end_blue;
    logic [7:0]  end_alpha;
    logic [8:0]  run_length;
    logic [30:0] max_distance;

    modport source (output valid, func, red, green, blue, alpha, end_red, end_green,
                    end_blue, end_alpha, run_length, max_distance, input ready);
    modport sink (input valid, func, red, green, blue, alpha, end_red, end_green,
                  end_blue, end_alpha, run_length, max_distance, output ready);
endinterface

interface pca_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  index;
    logic [30:0] distance;

    modport source (output valid, status, index, distance, input ready);
    modport sink (input valid, status, index, distance, output ready);
endinterface

FILE: rtl/core/palette_color_allocator.sv
// Palette color allocator top level: control sequencer, used flags, APB port.
// Depends on pca_pkg, pca_if, pca_ram, pca_div and pca_dist.
//
// One request at a time; a result register lets the next request enter while
// the previous result waits. Allocate scans the used flags one entry per cycle,
// runs the divider, then writes run_length palette entries (at least one), one
// per cycle. Begin-section scans the used flags one entry per cycle. Offer
// streams one palette RAM read per cycle through a four-stage distance
// pipeline. Unknown and refused requests go straight to the done state.
// The palette RAM needs no clearing after reset; used flags reset at once.
module palette_color_allocator
    import pca_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pca_req_if.sink     req,
    pca_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0] N9  = 9'(PALETTE_ENTRIES);
    localparam logic [9:0] N10 = 10'(PALETTE_ENTRIES);

    state_t state_reg, state_next;

    logic                   mode_reg;
    logic [PALETTE_ENTRIES-1:0] used_reg;
    logic [8:0]             fp_reg;
    logic [8:0]             d_reg, s_reg, t_reg, len_reg;
    logic [7:0]             red_reg, green_reg, blue_reg, alpha_reg;
    logic [7:0]             ered_reg, egreen_reg, eblue_reg, ealpha_reg;
    logic [30:0]            maxd_reg;
    logic [7:0]             acc_q_reg [4];
    logic [7:0]             acc_r_reg [4];

    logic [1:0]             res_status_reg;
    logic [7:0]             res_index_reg;
    logic [30:0]            res_dist_reg;
    logic                   out_valid_reg;
    logic [1:0]             out_status_reg;
    logic [7:0]             out_index_reg;
    logic [30:0]            out_dist_reg;

    logic                   accept;
    logic [9:0]             pos, d_step;
    logic                   blocked, found, fail;
    logic                   bfree, ocont, store, last_write;
    logic [8:0]             wpos;
    logic [7:0]             span;
    logic [7:0]             from_c [4];
    logic [7:0]             to_c [4];
    logic                   neg_c [4];
    logic [7:0]             mag_c [4];
    logic [7:0]             val_c [4];
    logic [7:0]             quo [4];
    logic [7:0]             rem [4];
    logic                   div_start, div_done;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [31:0]            ram_wdata, ram_rdata;
    logic                   used_set;
    logic [AW-1:0]          used_idx;
    logic                   res_load;
    logic [1:0]             res_status_n;
    logic [7:0]             res_index_n;
    logic [30:0]            res_dist_n;
    dist_ctl_t              dctl;
    dist_res_t              dres;
    logic                   cfg_we;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == ADDR_PALETTE_MODE);
    assign prdata = (paddr == ADDR_PALETTE_MODE) ? {31'd0, mode_reg} : 32'd0;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    // allocate search
    assign pos     = {1'b0, d_reg} + {1'b0, s_reg};
    assign blocked = (pos >= N10) || used_reg[pos[AW-1:0]];
    assign d_step  = {1'b0, d_reg} + {1'b0, len_reg};
    assign fail    = blocked && (d_step >= N10);
    assign found   = !blocked && ((s_reg + 9'd1) == len_reg);

    assign wpos       = d_reg + s_reg;
    assign span       = 8'(len_reg - 9'd1);
    assign last_write = (s_reg == len_reg - 9'd1);

    assign bfree = (t_reg >= N9) || !used_reg[t_reg[AW-1:0]];
    assign ocont = (t_reg < N9) && used_reg[t_reg[AW-1:0]];
    assign store = dres.best > maxd_reg;

    assign from_c = '{red_reg, green_reg, blue_reg, alpha_reg};
    assign to_c   = '{ered_reg, egreen_reg, eblue_reg, ealpha_reg};

    for (genvar c = 0; c < 4; c++)
    begin : g_chan
        assign neg_c[c] = to_c[c] < from_c[c];
        assign mag_c[c] = neg_c[c] ? from_c[c] - to_c[c] : to_c[c] - from_c[c];
        assign val_c[c] = neg_c[c] ? from_c[c] - acc_q_reg[c] : from_c[c] + acc_q_reg[c];
    end

    assign div_start = (state_reg == S_ALLOC_SEARCH) && found;

    pca_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_c),
        .divisor  (span),
        .done     (div_done),
        .quo      (quo),
        .rem      (rem)
    );

    pca_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pca_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dctl),
        .rdata (ram_rdata),
        .red   (red_reg),
        .green (green_reg),
        .blue  (blue_reg),
        .alpha (alpha_reg),
        .res   (dres)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.func)
                        FUNC_ALLOC: state_next = S_ALLOC_SEARCH;
                        FUNC_BEGIN: state_next = S_BEGIN_SCAN;
                        FUNC_OFFER: state_next = (mode_reg && fp_reg < N9) ? S_OFFER_SCAN
                                                                            : S_DONE;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_ALLOC_SEARCH:
            begin
                if (fail)
                begin
                    state_next = S_DONE;
                end
                else if (found)
                begin
                    state_next = S_ALLOC_DIV;
                end
            end
            S_ALLOC_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_ALLOC_WRITE;
                end
            end
            S_ALLOC_WRITE:
            begin
                if (last_write)
                begin
                    state_next = S_DONE;
                end
            end
            S_BEGIN_SCAN:
            begin
                if (bfree)
                begin
                    state_next = S_DONE;
                end
            end
            S_OFFER_SCAN:
            begin
                if (!ocont)
                begin
                    state_next = S_OFFER_DRAIN;
                end
            end
            S_OFFER_DRAIN:
            begin
                if (!dres.busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        ram_we       = 1'b0;
        ram_waddr    = wpos[AW-1:0];
        ram_wdata    = {val_c[0], val_c[1], val_c[2], val_c[3]};
        ram_re       = 1'b0;
        ram_raddr    = t_reg[AW-1:0];
        used_set     = 1'b0;
        used_idx     = wpos[AW-1:0];
        res_load     = 1'b0;
        res_status_n = ST_STORED;
        res_index_n  = 8'd0;
        res_dist_n   = 31'd0;
        dctl.clear   = 1'b0;
        dctl.issue   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_load   = 1'b1;
                    dctl.clear = 1'b1;
                    if (req.func == FUNC_OFFER)
                    begin
                        if (!mode_reg)
                        begin
                            res_status_n = ST_DISABLED;
                        end
                        else if (fp_reg >= N9)
                        begin
                            res_status_n = ST_NOROOM;
                        end
                    end
                end
            end
            S_ALLOC_SEARCH:
            begin
                if (fail)
                begin
                    res_load     = 1'b1;
                    res_status_n = ST_NOROOM;
                end
            end
            S_ALLOC_WRITE:
            begin
                ram_we   = 1'b1;
                used_set = 1'b1;
                if (last_write)
                begin
                    res_load    = 1'b1;
                    res_index_n = d_reg[7:0];
                end
            end
            S_BEGIN_SCAN:
            begin
                if (bfree)
                begin
                    res_load = 1'b1;
                    if (t_reg >= N9)
                    begin
                        res_status_n = ST_NOROOM;
                    end
                    else
                    begin
                        res_index_n = t_reg[7:0];
                    end
                end
            end
            S_OFFER_SCAN:
            begin
                if (ocont)
                begin
                    ram_re     = 1'b1;
                    dctl.issue = 1'b1;
                end
            end
            S_OFFER_DRAIN:
            begin
                ram_waddr = fp_reg[AW-1:0];
                ram_wdata = {red_reg, green_reg, blue_reg, alpha_reg};
                used_idx  = fp_reg[AW-1:0];
                if (!dres.busy)
                begin
                    res_load   = 1'b1;
                    res_dist_n = dres.best;
                    if (store)
                    begin
                        ram_we      = 1'b1;
                        used_set    = 1'b1;
                        res_index_n = fp_reg[7:0];
                    end
                    else
                    begin
                        res_status_n = ST_CLOSE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= 1'b1;
            used_reg      <= '0;
            fp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                mode_reg <= pwdata[0];
            end
            if (used_set)
            begin
                used_reg[used_idx] <= 1'b1;
            end
            if (state_reg == S_BEGIN_SCAN && bfree)
            begin
                fp_reg <= t_reg;
            end
            else if (state_reg == S_OFFER_DRAIN && !dres.busy && store)
            begin
                fp_reg <= fp_reg + 9'd1;
            end
            if (state_reg == S_DONE && (!out_valid_reg || rsp.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_reg    <= req.red;
            green_reg  <= req.green;
            blue_reg   <= req.blue;
            alpha_reg  <= req.alpha;
            ered_reg   <= req.end_red;
            egreen_reg <= req.end_green;
            eblue_reg  <= req.end_blue;
            ealpha_reg <= req.end_alpha;
            len_reg    <= (req.run_length == 9'd0) ? 9'd1 : req.run_length;
            maxd_reg   <= req.max_distance;
            d_reg      <= '0;
            s_reg      <= '0;
            t_reg      <= '0;
        end
        case (state_reg)
            S_ALLOC_SEARCH:
            begin
                if (blocked)
                begin
                    d_reg <= d_step[8:0];
                    s_reg <= '0;
                end
                else if (found)
                begin
                    s_reg <= '0;
                end
                else
                begin
                    s_reg <= s_reg + 9'd1;
                end
            end
            S_ALLOC_DIV:
            begin
                for (int c = 0; c < 4; c++)
                begin
                    acc_q_reg[c] <= '0;
                    acc_r_reg[c] <= '0;
                end
            end
            S_ALLOC_WRITE:
            begin
                s_reg <= s_reg + 9'd1;
                for (int c = 0; c < 4; c++)
                begin
                    logic [8:0] r_sum;
                    logic       ge;
                    r_sum = {1'b0, acc_r_reg[c]} + {1'b0, rem[c]};
                    ge    = r_sum >= {1'b0, span};
                    acc_r_reg[c] <= ge ? 8'(r_sum - {1'b0, span}) : r_sum[7:0];
                    acc_q_reg[c] <= acc_q_reg[c] + quo[c] + {7'd0, ge};
                end
            end
            S_BEGIN_SCAN:
            begin
                if (!bfree)
                begin
                    t_reg <= t_reg + 9'd1;
                end
            end
            S_OFFER_SCAN:
            begin
                if (ocont)
                begin
                    t_reg <= t_reg + 9'd1;
                end
            end
            default:
            begin
            end
        endcase
        if (res_load)
        begin
            res_status_reg <= res_status_n;
            res_index_reg  <= res_index_n;
            res_dist_reg   <= res_dist_n;
        end
        if (state_reg == S_DONE && (!out_valid_reg || rsp.ready))
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_dist_reg   <= res_dist_reg;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.index    = out_index_reg;
    assign rsp.distance = out_dist_reg;

endmodule

FILE: rtl/core/pca_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module pca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/pca_div.sv
// Four-lane 8-bit restoring divider, one quotient bit per cycle.
// Depends on pca_pkg.
module pca_div
    import pca_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] dividend [4],
    input  logic [7:0] divisor,
    output logic       done,
    output logic [7:0] quo [4],
    output logic [7:0] rem [4]
);

    logic [3:0] cnt_reg;
    logic       run_reg;
    logic [7:0] q_reg [4];
    logic [8:0] r_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            run_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg <= 4'd0;
            run_reg <= 1'b1;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'd7)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    assign done = run_reg && (cnt_reg == 4'd7);

    for (genvar c = 0; c < 4; c++)
    begin : g_lane
        logic [8:0] shifted;
        logic       ge;

        assign shifted = {r_reg[c][7:0], q_reg[c][7]};
        assign ge      = shifted >= {1'b0, divisor};

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                q_reg[c] <= dividend[c];
                r_reg[c] <= '0;
            end
            else if (run_reg)
            begin
                r_reg[c] <= ge ? shifted - {1'b0, divisor} : shifted;
                q_reg[c] <= {q_reg[c][6:0], ge};
            end
        end

        assign quo[c] = q_reg[c];
        assign rem[c] = r_reg[c][7:0];
    end

endmodule

FILE: rtl/core/pca_dist.sv
// Pipelined alpha-weighted distance and running minimum over palette reads.
// Depends on pca_pkg; fed by the palette RAM read port.
module pca_dist
    import pca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dist_ctl_t   ctl,
    input  logic [31:0] rdata,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  alpha,
    output dist_res_t   res
);

    logic        v1_reg, v2_reg, v3_reg;
    logic [17:0] sum_reg;
    logic [7:0]  wa_reg;
    logic [15:0] asq_reg;
    logic [26:0] prod_reg;
    logic [30:0] best_reg;

    logic [7:0]  dr, dg, db, da;
    logic [17:0] sum_next;

    function automatic logic [7:0] absdiff(input logic [7:0] x, input logic [7:0] y);
        return (x > y) ? x - y : y - x;
    endfunction

    assign dr = absdiff(red,   rdata[31:24]);
    assign dg = absdiff(green, rdata[23:16]);
    assign db = absdiff(blue,  rdata[15:8]);
    assign da = absdiff(alpha, rdata[7:0]);
    assign sum_next = 18'(dr * dr) + 18'(dg * dg) + 18'(db * db);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            best_reg <= DIST_LIMIT;
        end
        else
        begin
            v1_reg <= ctl.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (ctl.clear)
            begin
                best_reg <= DIST_LIMIT;
            end
            else if (v3_reg && ({4'd0, prod_reg} < best_reg))
            begin
                best_reg <= {4'd0, prod_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        wa_reg   <= CHAN_MAX - rdata[7:0];
        asq_reg  <= 16'(da * da);
        prod_reg <= 27'(wa_reg * sum_reg) + 27'(CHAN_MAX * asq_reg);
    end

    assign res.busy = v1_reg || v2_reg || v3_reg;
    assign res.best = best_reg;

endmodule

FILE: bench/palette_checker.sv
// Checker for the palette color allocator: watches both streams and the APB port.
// Depends on pca_pkg and pca_if; predicts each result and compares it in order.
`timescale 1ns / 1ps

module palette_checker
    import pca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pca_req_if          req,
    pca_rsp_if          rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          pending
);

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  index;
        logic [30:0] distance;
    } outcome_t;

    localparam int SLOTS = 64;

    logic [31:0] colors [256];
    logic        taken  [256];
    int          fill_ptr;
    logic        merge_on;
    outcome_t    awaited [SLOTS];
    int          head_cnt = 0;
    int          tail_cnt = 0;
    int          err_cnt = 0;

    function automatic logic [7:0] blend(int from, int to, int s, int span);
        return 8'(from + ((to - from) * s) / span);
    endfunction

    function automatic logic [31:0] nearest(int r, int g, int b, int a);
        logic [31:0] best;
        logic [31:0] sum;
        int pr, pg, pb, pa;
        best = 32'(DIST_LIMIT);
        for (int t = 0; t < 256; t++)
        begin
            if (!taken[t])
                break;
            pr = colors[t][31:24];
            pg = colors[t][23:16];
            pb = colors[t][15:8];
            pa = colors[t][7:0];
            sum = (255 - pa) * ((r - pr) * (r - pr) + (g - pg) * (g - pg) + (b - pb) * (b - pb))
                  + 255 * (a - pa) * (a - pa);
            if (sum < best)
                best = sum;
        end
        return best;
    endfunction

    function automatic outcome_t apply_request();
        outcome_t o;
        int len, d, s;
        logic fits;
        logic [31:0] near_d;
        o = '{ST_STORED, 8'd0, 31'd0};
        if (req.func == FUNC_ALLOC)
        begin
            len = (req.run_length == 0) ? 1 : int'(req.run_length);
            fits = 0;
            for (d = 0; d < 256; d += len)
            begin
                for (s = 0; s < len; s++)
                    if (d + s >= 256 || taken[d + s])
                        break;
                if (s == len)
                begin
                    fits = 1;
                    break;
                end
            end
            if (!fits)
                o.status = ST_NOROOM;
            else
            begin
                o.index = 8'(d);
                for (s = 0; s < len; s++)
                begin
                    taken[d + s] = 1;
                    if (s == 0)
                        colors[d] = {req.red, req.green, req.blue, req.alpha};
                    else
                        colors[d + s] = {blend(req.red, req.end_red, s, len - 1),
                                         blend(req.green, req.end_green, s, len - 1),
                                         blend(req.blue, req.end_blue, s, len - 1),
                                         blend(req.alpha, req.end_alpha, s, len - 1)};
                end
            end
        end
        else if (req.func == FUNC_BEGIN)
        begin
            for (d = 0; d < 256; d++)
                if (!taken[d])
                    break;
            fill_ptr = d;
            if (d >= 256)
                o.status = ST_NOROOM;
            else
                o.index = 8'(d);
        end
        else if (req.func == FUNC_OFFER)
        begin
            if (!merge_on)
                o.status = ST_DISABLED;
            else if (fill_ptr >= 256)
                o.status = ST_NOROOM;
            else
            begin
                near_d = nearest(req.red, req.green, req.blue, req.alpha);
                o.distance = 31'(near_d);
                if (near_d > {1'b0, req.max_distance})
                begin
                    colors[fill_ptr] = {req.red, req.green, req.blue, req.alpha};
                    taken[fill_ptr] = 1;
                    o.index = 8'(fill_ptr);
                    fill_ptr++;
                end
                else
                    o.status = ST_CLOSE;
            end
        end
        return o;
    endfunction

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            colors[i] = '0;
            taken[i] = 0;
        end
        fill_ptr = 0;
        merge_on = 1;
    end

    assign pending = tail_cnt - head_cnt;
    assign errors  = err_cnt;

    always @(posedge clk)
    begin
        outcome_t got, want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_PALETTE_MODE)
                merge_on = pwdata[0];
            if (req.valid && req.ready)
            begin
                awaited[tail_cnt % SLOTS] = apply_request();
                tail_cnt++;
            end
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.status, rsp.index, rsp.distance};
                if (head_cnt == tail_cnt)
                begin
                    $error("result transfer with nothing expected");
                    err_cnt++;
                end
                else
                begin
                    want = awaited[head_cnt % SLOTS];
                    head_cnt++;
                    if (got.status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, got.status);
                        err_cnt++;
                    end
                    if (got.index !== want.index)
                    begin
                        $error("index expected %0d got %0d", want.index, got.index);
                        err_cnt++;
                    end
                    if (got.distance !== want.distance)
                    begin
                        $error("distance expected %0d got %0d", want.distance, got.distance);
                        err_cnt++;
                    end
                end
            end
        end
    end

endmodule

FILE: bench/tb_top.sv
// Top of the palette color allocator bench: clock, reset, stimulus and verdict.
// Depends on pca_pkg, pca_if, palette_color_allocator and palette_checker.
`timescale 1ns / 1ps

module tb_top;
    import pca_pkg::*;

    typedef struct {
        logic [1:0]  func;
        logic [7:0]  red, green, blue, alpha;
        logic [7:0]  end_red, end_green, end_blue, end_alpha;
        logic [8:0]  run_length;
        logic [30:0] max_distance;
    } request_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    int          errors, pending;
    logic        quiet;
    logic        long_hold;
    int          stall_left;

    pca_req_if req_ch();
    pca_rsp_if rsp_ch();

    palette_color_allocator uut (
        .clk(clk), .rst_n(rst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    palette_checker checker_i (
        .clk(clk), .rst_n(rst_n), .req(req_ch), .rsp(rsp_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        #50ms;
        $display("tb_top failed");
        $finish;
    end

    // result side: random stalls, one long hold on request
    initial
    begin
        logic hold_done;
        hold_done = 0;
        rsp_ch.ready = 0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 0;
                stall_left--;
            end
            else if (long_hold && !hold_done)
            begin
                rsp_ch.ready <= 0;
                stall_left = 400;
                hold_done = 1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready <= 0;
                stall_left = $urandom_range(0, 16);
            end
            else
                rsp_ch.ready <= 1;
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(negedge clk);
    endtask

    task automatic send(request_t r);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        req_ch.valid <= 1;
        req_ch.func <= r.func;
        req_ch.red <= r.red;
        req_ch.green <= r.green;
        req_ch.blue <= r.blue;
        req_ch.alpha <= r.alpha;
        req_ch.end_red <= r.end_red;
        req_ch.end_green <= r.end_green;
        req_ch.end_blue <= r.end_blue;
        req_ch.end_alpha <= r.end_alpha;
        req_ch.run_length <= r.run_length;
        req_ch.max_distance <= r.max_distance;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic drain();
        req_ch.valid <= 0;
        wait (pending == 0);
        repeat (300) @(negedge clk);
    endtask

    function automatic request_t make(logic [1:0] f, logic [31:0] c, logic [31:0] e,
                                      logic [8:0] len, logic [30:0] maxd);
        request_t r;
        r.func = f;
        {r.red, r.green, r.blue, r.alpha} = c;
        {r.end_red, r.end_green, r.end_blue, r.end_alpha} = e;
        r.run_length = len;
        r.max_distance = maxd;
        return r;
    endfunction

    function automatic request_t random_request();
        int pick;
        logic [8:0] len;
        logic [30:0] maxd;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: maxd = 31'($urandom_range(0, 20000));
            1: maxd = 31'd15500;
            2: maxd = 31'($urandom);
            default: maxd = 31'($urandom_range(0, 1 << 26));
        endcase
        len = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(1, 8));
        return make(pick < 65 ? FUNC_OFFER : pick < 82 ? FUNC_ALLOC :
                    pick < 95 ? FUNC_BEGIN : FUNC_NONE,
                    $urandom, $urandom, len, maxd);
    endfunction

    initial
    begin
        clk = 0;
        rst_n = 0;
        quiet = 0;
        long_hold = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 0;
        req_ch.func = FUNC_ALLOC;
        {req_ch.red, req_ch.green, req_ch.blue, req_ch.alpha} = '0;
        {req_ch.end_red, req_ch.end_green, req_ch.end_blue, req_ch.end_alpha} = '0;
        req_ch.run_length = 9'd1;
        req_ch.max_distance = '0;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        reg_write(ADDR_PALETTE_MODE, 32'd1);

        // directed: empty palette, extremes, gradients, fill pointer behavior
        send(make(FUNC_BEGIN, 0, 0, 1, 0));
        send(make(FUNC_OFFER, 32'h10203040, 0, 1, 31'(1 << 30)));
        send(make(FUNC_OFFER, 32'h10203040, 0, 1, 31'h7fffffff));
        send(make(FUNC_OFFER, 32'h000000ff, 0, 1, 0));
        send(make(FUNC_ALLOC, 32'h00ff00ff, 32'hff00ff00, 9'd0, 0));
        send(make(FUNC_ALLOC, 32'h00000000, 32'hffffffff, 9'd3, 0));
        send(make(FUNC_ALLOC, 32'hffffffff, 32'h00000000, 9'd4, 0));
        send(make(FUNC_ALLOC, 32'h12345678, 32'h9abcdef0, 9'd7, 0));
        send(make(FUNC_ALLOC, 32'h0, 32'h0, 9'd256, 0));
        send(make(FUNC_ALLOC, 32'h0, 32'h0, 9'd511, 0));
        send(make(FUNC_ALLOC, 32'h0, 32'h0, 9'd257, 0));
        send(make(FUNC_NONE, 32'hffffffff, 32'hffffffff, 9'd511, 31'h7fffffff));
        send(make(FUNC_BEGIN, 0, 0, 1, 0));
        send(make(FUNC_OFFER, 32'h00000000, 0, 1, 0));
        send(make(FUNC_OFFER, 32'hffffffff, 0, 1, 31'd15500));
        send(make(FUNC_OFFER, 32'h01010101, 0, 1, 31'd15500));
        send(make(FUNC_OFFER, 32'h80808000, 0, 1, 0));
        send(make(FUNC_BEGIN, 0, 0, 1, 0));
        drain();

        reg_write(ADDR_PALETTE_MODE, 32'd0);
        send(make(FUNC_OFFER, 32'hffffffff, 0, 1, 0));
        for (int i = 0; i < 100; i++)
            send(random_request());
        drain();

        reg_write(ADDR_PALETTE_MODE, 32'd1);
        for (int i = 0; i < 1400; i++)
        begin
            if (i == 100)
                long_hold = 1;
            if (i == 300)
            begin
                req_ch.valid <= 0;
                wait (pending == 0);
                @(negedge clk);
            end
            if (i == 1250)
                quiet = 1;
            send(random_request());
        end
        req_ch.valid <= 0;
        wait (pending == 0);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
